// File: src/ouart_pkg.sv
// Package for the oversampled UART: command codes, frame timing, register map
// and the result beat type. Used by the result queue and the top level.
`timescale 1ns / 1ps

package ouart_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_PUSH = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;

    // frame timing, in ticks of 1/16 bit
    localparam logic [4:0] HALF_BIT_WAIT = 5'd7;
    localparam logic [4:0] BIT_WAIT      = 5'd15;
    localparam logic [4:0] START_WAIT    = 5'd23;
    localparam int         FRAME_TICKS   = 10 * (int'(BIT_WAIT) + 1);
    localparam logic [8:0] IDLE_TIMEOUT  = 9'(2 * FRAME_TICKS);

    // bit engine phases: start, eight data bits, stop
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_STOP  = 4'd9;

    // FIFO depth default
    localparam int FIFO_DEPTH_DEF = 64;

    // register map (word index in paddr[3:2])
    localparam int         PADDR_W        = 4;
    localparam logic [1:0] REG_TX_ENABLE  = 2'd0;
    localparam logic [1:0] REG_RX_ENABLE  = 2'd1;
    localparam logic [1:0] REG_NEED_COUNT = 2'd2;
    localparam logic [1:0] REG_END_CHAR   = 2'd3;

    // result queue size
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

    typedef struct packed {
        logic       tx_line;
        logic       push_accepted;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic [5:0] rx_count;
        logic       notify;
    } t_result;

endpackage

// File: src/ouart_res_queue.sv
// Small result queue that decouples the UART core from the output stall.
// Depends on ouart_pkg for t_result and the queue size.
`timescale 1ns / 1ps

module ouart_res_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ouart_pkg::t_result            i_data,
    input  logic                          i_pop,
    output ouart_pkg::t_result            o_data,
    output logic                          o_valid,
    output logic [ouart_pkg::RQ_AW:0]     o_count
);
    import ouart_pkg::*;

    t_result            r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]   r_wr_ptr;
    logic [RQ_AW-1:0]   r_rd_ptr;
    logic [RQ_AW:0]     r_count;
    logic               do_pop;

    assign do_pop  = i_pop & (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/oversampled_uart_with_fifos.sv
// UART, 8N1 with 16x oversampling, with transmit and receive ring FIFOs.
// Results pass through stage 1 and then the result queue to the output.
// Throughput: one item per cycle, set by the pointer and engine update around
// the two FIFO memories; input stalls only when stage 1 and the result queue
// together hold 4 beats. Reset: synchronous, active low; control state clears,
// the FIFO memories are not cleared. Uses ouart_pkg.
`timescale 1ns / 1ps

module oversampled_uart_with_fifos #(
    parameter int FIFO_DEPTH = ouart_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_command,
    input  logic                           i_rx_line,
    input  logic [7:0]                     i_tx_data,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_tx_line,
    output logic                           o_push_accepted,
    output logic [7:0]                     o_rx_data,
    output logic                           o_rx_valid,
    output logic [5:0]                     o_rx_count,
    output logic                           o_notify,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ouart_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ouart_pkg::*;

    localparam int AW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNTW = (AW > 8) ? AW + 1 : 9;
    localparam logic [AW-1:0]   LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(FIFO_DEPTH);

    // configuration registers
    logic              r_tx_enable;
    logic              r_rx_enable;
    logic signed [8:0] r_need_count;
    logic [7:0]        r_end_char;
    logic              cfg_wr;

    // FIFO memories
    logic [7:0]    tx_mem [FIFO_DEPTH];
    logic [7:0]    rx_mem [FIFO_DEPTH];
    logic [7:0]    r_tx_q;
    logic [7:0]    r_rx_q;

    // control state
    logic [AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [3:0]    r_tx_phase, n_tx_phase, r_rx_phase, n_rx_phase;
    logic [4:0]    r_tx_wait, n_tx_wait, r_rx_wait, n_rx_wait;
    logic [7:0]    r_tx_shift, n_tx_shift, r_rx_shift, n_rx_shift;
    logic          r_tx_level, n_tx_level;
    logic [8:0]    r_idle_wait, n_idle_wait;
    logic          r_tx_load, n_tx_load;

    // memory strobes
    logic          tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;

    // stage 1 and result queue
    logic          r_s1_valid;
    t_result       r_s1, n_s1;
    t_result       s1_res;
    logic [RQ_AW:0] q_count;
    logic          in_acc;

    // step-local values
    logic [AW-1:0]   tx_head_nx, rx_head_nx, rx_tail_nx;
    logic [CNTW-1:0] rx_cnt_new;
    logic            notify;
    logic            push_ok;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [CNTW-1:0] ring_count(input logic [AW-1:0] h,
                                                   input logic [AW-1:0] t);
        logic [CNTW-1:0] d;
        d = CNTW'(h) - CNTW'(t);
        return (h < t) ? d + DEPTH_C : d;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_enable  <= 1'b0;
            r_rx_enable  <= 1'b0;
            r_need_count <= '0;
            r_end_char   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TX_ENABLE:  r_tx_enable  <= pwdata[0];
                REG_RX_ENABLE:  r_rx_enable  <= pwdata[0];
                REG_NEED_COUNT: r_need_count <= pwdata[8:0];
                REG_END_CHAR:   r_end_char   <= pwdata[7:0];
                default:        r_tx_enable  <= r_tx_enable;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TX_ENABLE:  prdata = {31'd0, r_tx_enable};
            REG_RX_ENABLE:  prdata = {31'd0, r_rx_enable};
            REG_NEED_COUNT: prdata = {23'd0, r_need_count};
            REG_END_CHAR:   prdata = {24'd0, r_end_char};
            default:        prdata = '0;
        endcase
    end

    // input handshake: stall when the result queue could overflow
    assign o_in_stall = (q_count + (RQ_AW+1)'(r_s1_valid)) >= (RQ_AW+1)'(RQ_DEPTH);
    assign in_acc     = i_in_valid & ~o_in_stall;

    // step logic: commands, bit engines and FIFO pointers
    always_comb begin
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_phase  = r_tx_phase;
        n_tx_wait   = r_tx_wait;
        // byte popped last cycle arrives from the memory now
        n_tx_shift  = r_tx_load ? r_tx_q : r_tx_shift;
        n_tx_level  = r_tx_level;
        n_rx_phase  = r_rx_phase;
        n_rx_wait   = r_rx_wait;
        n_rx_shift  = r_rx_shift;
        n_idle_wait = r_idle_wait;
        n_tx_load   = 1'b0;
        tx_wr_en    = 1'b0;
        tx_rd_en    = 1'b0;
        rx_wr_en    = 1'b0;
        rx_rd_en    = 1'b0;
        notify      = 1'b0;
        push_ok     = 1'b0;
        tx_head_nx  = ring_next(r_tx_head);
        rx_head_nx  = ring_next(r_rx_head);
        rx_tail_nx  = ring_next(r_rx_tail);
        rx_cnt_new  = ring_count(rx_head_nx, r_rx_tail);

        if (in_acc) begin
            case (i_command)
                CMD_TICK: begin
                    // transmitter
                    if (r_tx_enable) begin
                        if (r_tx_wait != '0) begin
                            n_tx_wait = r_tx_wait - 1'b1;
                        end else if (r_tx_phase == PH_START) begin
                            if (r_tx_head != r_tx_tail) begin
                                tx_rd_en   = 1'b1;
                                n_tx_load  = 1'b1;
                                n_tx_tail  = ring_next(r_tx_tail);
                                n_tx_level = 1'b0;
                                n_tx_wait  = BIT_WAIT;
                                n_tx_phase = 4'd1;
                            end
                        end else if (r_tx_phase < PH_STOP) begin
                            n_tx_level = n_tx_shift[0];
                            n_tx_shift = {1'b0, n_tx_shift[7:1]};
                            n_tx_wait  = BIT_WAIT;
                            n_tx_phase = r_tx_phase + 1'b1;
                        end else if (r_tx_phase == PH_STOP) begin
                            n_tx_level = 1'b1;
                            n_tx_wait  = BIT_WAIT;
                            n_tx_phase = PH_START;
                        end else begin
                            n_tx_wait  = '0;
                            n_tx_phase = PH_START;
                        end
                    end
                    // receiver
                    if (r_rx_enable) begin
                        if (r_rx_wait != '0) begin
                            n_rx_wait = r_rx_wait - 1'b1;
                        end else if (r_rx_phase == PH_START) begin
                            if (!i_rx_line) begin
                                n_rx_wait  = START_WAIT;
                                n_rx_phase = 4'd1;
                            end else if (r_idle_wait != '0) begin
                                n_idle_wait = r_idle_wait - 1'b1;
                                notify      = (r_idle_wait == 9'd1);
                            end
                        end else if (r_rx_phase < PH_STOP) begin
                            n_rx_shift = {i_rx_line, r_rx_shift[7:1]};
                            n_rx_wait  = BIT_WAIT;
                            n_rx_phase = r_rx_phase + 1'b1;
                        end else if (r_rx_phase == PH_STOP) begin
                            // store only on a good stop bit with room left
                            if (i_rx_line && (rx_head_nx != r_rx_tail)) begin
                                rx_wr_en  = 1'b1;
                                n_rx_head = rx_head_nx;
                                if (!r_need_count[8] && (r_need_count != '0)) begin
                                    notify = rx_cnt_new >= CNTW'(r_need_count[7:0]);
                                end else if (r_need_count[8]) begin
                                    n_idle_wait = IDLE_TIMEOUT;
                                end else begin
                                    notify = (r_rx_shift == r_end_char);
                                end
                            end
                            n_rx_wait  = HALF_BIT_WAIT;
                            n_rx_phase = PH_START;
                        end else begin
                            n_rx_wait  = '0;
                            n_rx_phase = PH_START;
                        end
                    end
                end
                CMD_PUSH: begin
                    if (tx_head_nx != r_tx_tail) begin
                        tx_wr_en  = 1'b1;
                        push_ok   = 1'b1;
                        n_tx_head = tx_head_nx;
                    end
                end
                CMD_POP: begin
                    if (r_rx_head != r_rx_tail) begin
                        rx_rd_en  = 1'b1;
                        n_rx_tail = rx_tail_nx;
                    end
                end
                default: begin
                    push_ok = 1'b0;
                end
            endcase
        end

        // result fields known now; popped byte joins in the next stage
        n_s1.tx_line       = n_tx_level;
        n_s1.push_accepted = push_ok;
        n_s1.rx_data       = '0;
        n_s1.rx_valid      = rx_rd_en;
        n_s1.rx_count      = 6'(ring_count(n_rx_head, n_rx_tail));
        n_s1.notify        = notify;
    end

    // FIFO memories, registered read
    always_ff @(posedge i_clk) begin
        if (tx_wr_en) begin
            tx_mem[r_tx_head] <= i_tx_data;
        end
        if (tx_rd_en) begin
            r_tx_q <= tx_mem[r_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_wr_en) begin
            rx_mem[r_rx_head] <= r_rx_shift;
        end
        if (rx_rd_en) begin
            r_rx_q <= rx_mem[r_rx_tail];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_tx_phase  <= PH_START;
            r_tx_wait   <= '0;
            r_tx_shift  <= '0;
            r_tx_level  <= 1'b1;
            r_rx_phase  <= PH_START;
            r_rx_wait   <= '0;
            r_rx_shift  <= '0;
            r_idle_wait <= '0;
            r_tx_load   <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_tx_phase  <= n_tx_phase;
            r_tx_wait   <= n_tx_wait;
            r_tx_shift  <= n_tx_shift;
            r_tx_level  <= n_tx_level;
            r_rx_phase  <= n_rx_phase;
            r_rx_wait   <= n_rx_wait;
            r_rx_shift  <= n_rx_shift;
            r_idle_wait <= n_idle_wait;
            r_tx_load   <= n_tx_load;
            r_s1_valid  <= in_acc;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        s1_res = r_s1;
        if (r_s1.rx_valid) begin
            s1_res.rx_data = r_rx_q;
        end
    end

    // result queue
    t_result q_data;

    ouart_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_res),
        .i_pop   (~i_out_stall),
        .o_data  (q_data),
        .o_valid (o_out_valid),
        .o_count (q_count)
    );

    assign o_tx_line       = q_data.tx_line;
    assign o_push_accepted = q_data.push_accepted;
    assign o_rx_data       = q_data.rx_data;
    assign o_rx_valid      = q_data.rx_valid;
    assign o_rx_count      = q_data.rx_count;
    assign o_notify        = q_data.notify;

`ifndef SYNTHESIS
    // queue plus stage 1 never exceed the queue depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count + (RQ_AW+1)'(r_s1_valid)) <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("result queue overflow");

    // stage 1 holds a beat only for an item accepted in the previous cycle
    a_s1_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(in_acc))
        else $error("stage 1 beat without accepted item");

    // popped tx byte lands while the start bit is still being held
    a_tx_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_load |-> (r_tx_wait == BIT_WAIT) && (r_tx_phase == 4'd1))
        else $error("tx byte load outside start bit");
`endif

endmodule

// File: tb/tb_oversampled_uart_with_fifos.sv
// Self-checking bench for the oversampled UART with FIFOs: random command beats with
// mostly well-formed 8N1 receive frames, and a shadow model that checks every result beat.
// Depends on ouart_pkg and oversampled_uart_with_fifos.
`timescale 1ns / 1ps

module tb_oversampled_uart_with_fifos;
    import ouart_pkg::*;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam int         DEPTH       = FIFO_DEPTH_DEF;
    localparam int         STUCK_LIMIT = 400;
    localparam int         MAX_LINES   = 100;

    // shadow of the UART state plus the queue of result beats still owed
    class t_uart_scoreboard;
        logic [7:0]        tx_mem [DEPTH];
        logic [7:0]        rx_mem [DEPTH];
        logic [5:0]        tx_hd, tx_tl, rx_hd, rx_tl;
        logic [3:0]        tx_ph, rx_ph;
        logic [4:0]        tx_cnt, rx_cnt;
        logic [7:0]        tx_sh, rx_sh;
        logic              tx_lvl;
        logic [8:0]        idle_cnt;
        logic              tx_en, rx_en;
        logic signed [8:0] need;
        logic [7:0]        eol;
        t_result           expected_beats[$];
        int                mismatches;
        int                beat_no;

        function new();
            tx_hd = '0; tx_tl = '0; rx_hd = '0; rx_tl = '0;
            tx_ph = PH_START; rx_ph = PH_START;
            tx_cnt = '0; rx_cnt = '0;
            tx_sh = '0; rx_sh = '0;
            tx_lvl = 1'b1;
            idle_cnt = '0;
            tx_en = 1'b0; rx_en = 1'b0; need = '0; eol = '0;
            mismatches = 0;
            beat_no = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_TX_ENABLE:  tx_en = val[0];
                REG_RX_ENABLE:  rx_en = val[0];
                REG_NEED_COUNT: need = val[8:0];
                REG_END_CHAR:   eol = val[7:0];
                default: ;
            endcase
        endfunction

        // one tick of the bit transmitter
        function void tx_step();
            if (tx_cnt != 0) begin
                tx_cnt = tx_cnt - 5'd1;
            end else if (tx_ph == PH_START) begin
                if (tx_hd != tx_tl) begin
                    tx_sh = tx_mem[tx_tl];
                    tx_tl = tx_tl + 6'd1;
                    tx_lvl = 1'b0;
                    tx_cnt = BIT_WAIT;
                    tx_ph = 4'd1;
                end
            end else if (tx_ph < PH_STOP) begin
                tx_lvl = tx_sh[0];
                tx_sh = tx_sh >> 1;
                tx_cnt = BIT_WAIT;
                tx_ph = tx_ph + 4'd1;
            end else if (tx_ph == PH_STOP) begin
                tx_lvl = 1'b1;
                tx_cnt = BIT_WAIT;
                tx_ph = PH_START;
            end else begin
                tx_cnt = '0;
                tx_ph = PH_START;
            end
        endfunction

        // one tick of the bit receiver, returns the notify condition
        function logic rx_step(logic line);
            logic       fire;
            logic [5:0] fill;
            fire = 1'b0;
            if (rx_cnt != 0) begin
                rx_cnt = rx_cnt - 5'd1;
            end else if (rx_ph == PH_START) begin
                if (!line) begin
                    rx_cnt = START_WAIT;
                    rx_ph = 4'd1;
                end else if (idle_cnt != 0) begin
                    idle_cnt = idle_cnt - 9'd1;
                    if (idle_cnt == 0) fire = 1'b1;
                end
            end else if (rx_ph < PH_STOP) begin
                rx_sh = {line, rx_sh[7:1]};
                rx_cnt = BIT_WAIT;
                rx_ph = rx_ph + 4'd1;
            end else if (rx_ph == PH_STOP) begin
                // good stop bit and room in the ring: keep the byte
                if (line && (rx_hd + 6'd1 != rx_tl)) begin
                    rx_mem[rx_hd] = rx_sh;
                    rx_hd = rx_hd + 6'd1;
                    fill = rx_hd - rx_tl;
                    if (need > 0) begin
                        if (int'(fill) >= int'(need)) fire = 1'b1;
                    end else if (need < 0) begin
                        idle_cnt = IDLE_TIMEOUT;
                    end else if (rx_sh == eol) begin
                        fire = 1'b1;
                    end
                end
                rx_cnt = HALF_BIT_WAIT;
                rx_ph = PH_START;
            end else begin
                rx_cnt = '0;
                rx_ph = PH_START;
            end
            return fire;
        endfunction

        // accepted command beat: advance the shadow and queue its result
        function void take_item(logic [1:0] cmd, logic line, logic [7:0] data);
            t_result r;
            r = '0;
            case (cmd)
                CMD_TICK: begin
                    if (tx_en) tx_step();
                    if (rx_en) r.notify = rx_step(line);
                end
                CMD_PUSH: begin
                    if (tx_hd + 6'd1 != tx_tl) begin
                        tx_mem[tx_hd] = data;
                        tx_hd = tx_hd + 6'd1;
                        r.push_accepted = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (rx_hd != rx_tl) begin
                        r.rx_data = rx_mem[rx_tl];
                        r.rx_valid = 1'b1;
                        rx_tl = rx_tl + 6'd1;
                    end
                end
                default: ;
            endcase
            r.tx_line = tx_lvl;
            r.rx_count = rx_hd - rx_tl;
            expected_beats.push_back(r);
        endfunction

        task flag(string msg);
            if (mismatches < MAX_LINES) $display("[%0t] MISMATCH beat %0d: %s", $time, beat_no, msg);
            mismatches++;
        endtask

        task cmp(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) flag($sformatf("%s expected %h got %h", field, want, got));
        endtask

        task check_beat(t_result got);
            t_result want;
            if (expected_beats.size() == 0) begin
                flag($sformatf("result beat %h with nothing expected", got));
            end else begin
                want = expected_beats.pop_front();
                cmp("tx_line", 8'(want.tx_line), 8'(got.tx_line));
                cmp("push_accepted", 8'(want.push_accepted), 8'(got.push_accepted));
                cmp("rx_data", want.rx_data, got.rx_data);
                cmp("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
                cmp("rx_count", 8'(want.rx_count), 8'(got.rx_count));
                cmp("notify", 8'(want.notify), 8'(got.notify));
            end
            beat_no++;
        endtask
    endclass

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_command = CMD_NONE;
    logic        i_rx_line = 1'b1;
    logic [7:0]  i_tx_data = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall, o_out_valid;
    logic        o_tx_line, o_push_accepted, o_rx_valid, o_notify;
    logic [7:0]  o_rx_data;
    logic [5:0]  o_rx_count;
    logic [31:0] prdata;
    logic        pready;

    t_uart_scoreboard sb;

    // sender burst state and receive-frame generator state
    int          burst_left = 0;
    logic [9:0]  rx_frame = '1;
    int          frame_pos = 0;
    logic        in_frame = 1'b0;
    int          gap_left = 0;
    logic [7:0]  eol_pick = 8'h00;
    logic        favor_eol = 1'b0;
    logic        long_gaps = 1'b0;

    oversampled_uart_with_fifos uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_rx_line       (i_rx_line),
        .i_tx_data       (i_tx_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_line       (o_tx_line),
        .o_push_accepted (o_push_accepted),
        .o_rx_data       (o_rx_data),
        .o_rx_valid      (o_rx_valid),
        .o_rx_count      (o_rx_count),
        .o_notify        (o_notify),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result-side stall pattern, switching between modes every so often
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_tick = 0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:     i_out_stall <= ((stall_tick % 5) < 3);
        endcase
    end

    // monitor: note accepted beats, check result beats, watch for a hang
    int stuck = 0;
    always @(posedge i_clk) begin
        logic    got_in, got_out;
        t_result seen;
        got_in = i_rst_n && i_in_valid && !o_in_stall;
        got_out = i_rst_n && o_out_valid && !i_out_stall;
        if (got_in) sb.take_item(i_command, i_rx_line, i_tx_data);
        if (got_out) begin
            seen.tx_line = o_tx_line;
            seen.push_accepted = o_push_accepted;
            seen.rx_data = o_rx_data;
            seen.rx_valid = o_rx_valid;
            seen.rx_count = o_rx_count;
            seen.notify = o_notify;
            sb.check_beat(seen);
        end
        if (got_in || got_out) stuck = 0;
        else stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // drive one command beat; called and returns at a falling edge
    task automatic send_beat(input logic [1:0] cmd, input logic line, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_rx_line <= line;
        i_tx_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // hold off the sender until every owed result beat is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic tx_on, input logic rx_on,
                                input logic [8:0] need, input logic [7:0] eol);
        drain();
        repeat (4) @(negedge i_clk);
        reg_write(REG_TX_ENABLE, {31'd0, tx_on});
        reg_write(REG_RX_ENABLE, {31'd0, rx_on});
        reg_write(REG_NEED_COUNT, {23'd0, need});
        reg_write(REG_END_CHAR, {24'd0, eol});
    endtask

    // next receive-line sample: 8N1 frames at 16 ticks per bit, idle gaps, rare glitches
    function automatic logic next_line();
        logic       lvl;
        logic [7:0] b;
        if (!in_frame && gap_left == 0) begin
            b = (favor_eol && $urandom_range(0, 1) == 0) ? eol_pick : 8'($urandom);
            rx_frame = {($urandom_range(0, 7) != 0), b, 1'b0};
            frame_pos = 0;
            in_frame = 1'b1;
        end
        if (in_frame) begin
            lvl = rx_frame[frame_pos / 16];
            frame_pos++;
            if (frame_pos == 160) begin
                in_frame = 1'b0;
                if (long_gaps ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 5) == 0))
                    gap_left = $urandom_range(330, 380);
                else
                    gap_left = $urandom_range(0, 24);
            end
        end else begin
            lvl = 1'b1;
            gap_left--;
        end
        if ($urandom_range(0, 99) == 0) lvl = ~lvl;
        return lvl;
    endfunction

    task automatic run_phase(input logic tx_on, input logic rx_on, input logic [8:0] need,
                             input logic [7:0] eol, input int items, input int pushes,
                             input bit hold_mid);
        logic [1:0] cmd;
        logic       line;
        int         r;
        program_regs(tx_on, rx_on, need, eol);
        eol_pick = eol;
        favor_eol = (need == 9'd0);
        long_gaps = need[8];
        // idle-timeout mode wants a fresh frame followed by a long quiet line
        if (need[8]) begin
            in_frame = 1'b0;
            gap_left = 0;
        end
        repeat (pushes) send_beat(CMD_PUSH, 1'($urandom), 8'($urandom));
        for (int k = 0; k < items; k++) begin
            if (hold_mid && k == items / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 88) begin
                cmd = CMD_TICK;
                line = next_line();
            end else begin
                cmd = (r < 94) ? CMD_PUSH : (r < 99) ? CMD_POP : CMD_NONE;
                line = 1'($urandom);
            end
            send_beat(cmd, line, 8'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // both engines off after reset: ticks change nothing
        send_beat(CMD_POP, 1'b1, 8'h00);
        send_beat(CMD_PUSH, 1'b0, 8'h00);
        send_beat(CMD_PUSH, 1'b1, 8'hFF);
        send_beat(CMD_NONE, 1'b0, 8'hA5);
        send_beat(CMD_TICK, 1'b0, 8'h00);
        send_beat(CMD_TICK, 1'b1, 8'hFF);

        // engines on: transmitter picks up the queued byte, receiver sees a start
        program_regs(1'b1, 1'b1, 9'd1, 8'hFF);
        send_beat(CMD_TICK, 1'b1, 8'h00);
        send_beat(CMD_TICK, 1'b0, 8'h00);
        send_beat(CMD_PUSH, 1'b0, 8'h80);
        send_beat(CMD_PUSH, 1'b1, 8'h7F);
        send_beat(CMD_PUSH, 1'b0, 8'h01);
        send_beat(CMD_POP, 1'b0, 8'h00);
        send_beat(CMD_NONE, 1'b1, 8'hFF);
        repeat (6) send_beat(CMD_TICK, 1'b0, 8'($urandom));

        // random phases over several register settings
        run_phase(1'b1, 1'b1, 9'd1, 8'h00, 160, 0, 1'b1);
        run_phase(1'b1, 1'b1, 9'd0, 8'hA5, 180, 0, 1'b0);
        run_phase(1'b1, 1'b1, 9'h1FF, 8'hFF, 520, 0, 1'b0);
        run_phase(1'b0, 1'b1, 9'd255, 8'h3C, 90, 66, 1'b0);
        run_phase(1'b1, 1'b0, 9'd2, 8'h00, 80, 0, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
